[src/cbm_pkg.sv]
`timescale 1ns / 1ps

package cbm_pkg;

  // Cartridge RAM size in bytes and its address width
  localparam int RAM_DEPTH = 32768;
  localparam int RAM_AW    = $clog2(RAM_DEPTH);

  // ROM bank number width and the bits of rom_bank_mask that are used
  localparam int ROM_BANK_BITS = 7;
  localparam logic [6:0] ROM_LIMIT_MASK = 7'((1 << ROM_BANK_BITS) - 1);

  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    SRC_NONE = 2'd0,
    SRC_ROM  = 2'd1,
    SRC_RAM  = 2'd2
  } src_t;

  typedef enum logic [1:0] {
    CFG_ROM_BANK_MASK = 2'd0,
    CFG_RAM_PRESENT   = 2'd1,
    CFG_RAM_BANK_MASK = 2'd2
  } cfg_idx_t;

  // Address decode on bus_address[15:13]
  localparam logic [2:0] REGION_RAM_EN   = 3'b000;
  localparam logic [2:0] REGION_ROM_BANK = 3'b001;
  localparam logic [2:0] REGION_UPPER    = 3'b010;
  localparam logic [2:0] REGION_MODE     = 3'b011;
  localparam logic [2:0] REGION_CART_RAM = 3'b101;

  localparam logic [3:0] RAM_EN_KEY = 4'hA;
  localparam logic [7:0] OPEN_BUS   = 8'hFF;

endpackage

[src/cartridge_bank_mapper_top.sv]
`timescale 1ns / 1ps

// Bank controller for a game cartridge: one CPU bus access per transaction.
// Input channel: in_tuser carries the access kind (read or write), in_tdata
// the address and the write byte. Writes below 0x8000 load the bank
// registers; writes at 0xA000-0xBFFF store into the internal cartridge RAM
// when RAM is present and enabled. Every access gives exactly one result
// transaction: out_tuser says where the data comes from (none, ROM, RAM);
// a ROM read returns the mapped ROM byte address and a RAM read returns the
// stored byte.
// The result is registered and appears in the cycle after the input transaction
// is accepted; one transaction is accepted every cycle while the receiver does not
// stall. The synchronous read port of the cartridge RAM drives the result directly.
// When the receiver stalls, the result is held and the input is stalled too
// (in_tready follows out_tready while a result waits); the RAM read register
// only loads on an accepted transaction, so held data stays put.
// Reset clears the bank registers and configuration to their defaults and
// empties the result stage; RAM contents are not cleared and must be written
// before they are read.
module cartridge_bank_mapper_top
  import cbm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [15:0] bus_address, [23:16] write_byte
  input  logic        in_tuser,   // [0] operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [20:0] rom_address, [28:21] read_byte, rest zero
  output logic [1:0]  out_tuser   // [1:0] source
);

  logic [6:0] rom_bank_mask_r;
  logic       ram_present_r;
  logic [1:0] ram_bank_mask_r;

  logic       ram_en_r, ram_en_nxt;
  logic [4:0] low_bank_r, low_bank_nxt;
  logic [1:0] upper_r, upper_nxt;
  logic       mode_r, mode_nxt;

  logic [7:0] cart_ram [RAM_DEPTH];
  logic [7:0] ram_q_r;

  logic        out_valid_r;
  src_t        src_r, src_nxt;
  logic [20:0] rom_addr_r, rom_addr_nxt;

  logic        in_acc;
  op_t         op;
  logic [15:0] addr;
  logic [7:0]  wbyte;
  logic [2:0]  region;
  logic        ram_ok;
  logic [1:0]  ram_bank;
  logic [RAM_AW-1:0] ram_idx;
  logic [14:0] ram_full_idx;
  logic [6:0]  rom_bank;
  logic        ram_we, ram_re;
  logic [7:0]  read_byte;

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  assign op     = op_t'(in_tuser);
  assign addr   = in_tdata[15:0];
  assign wbyte  = in_tdata[23:16];
  assign region = addr[15:13];

  assign ram_ok       = ram_en_r && ram_present_r && (region == REGION_CART_RAM);
  assign ram_bank     = mode_r ? (upper_r & ram_bank_mask_r) : 2'd0;
  assign ram_full_idx = {ram_bank, addr[12:0]};
  assign ram_idx      = ram_full_idx[RAM_AW-1:0];

  always_comb begin
    if (addr[14]) begin
      rom_bank = {upper_r, low_bank_r} & rom_bank_mask_r & ROM_LIMIT_MASK;
    end else if (mode_r) begin
      rom_bank = {upper_r, 5'd0} & rom_bank_mask_r & ROM_LIMIT_MASK;
    end else begin
      rom_bank = 7'd0;
    end
  end

  always_comb begin
    ram_en_nxt   = ram_en_r;
    low_bank_nxt = low_bank_r;
    upper_nxt    = upper_r;
    mode_nxt     = mode_r;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    src_nxt      = SRC_NONE;
    rom_addr_nxt = 21'd0;
    if (op == OP_WRITE) begin
      case (region)
        REGION_RAM_EN:   ram_en_nxt = (wbyte[3:0] == RAM_EN_KEY);
        REGION_ROM_BANK: low_bank_nxt = (wbyte[4:0] == 5'd0) ? 5'd1 : wbyte[4:0];
        REGION_UPPER:    upper_nxt = wbyte[1:0];
        REGION_MODE:     mode_nxt = wbyte[0];
        default:         ram_we = ram_ok;
      endcase
    end else if (!addr[15]) begin
      src_nxt      = SRC_ROM;
      rom_addr_nxt = {rom_bank, addr[13:0]};
    end else if (ram_ok) begin
      src_nxt = SRC_RAM;
      ram_re  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rom_bank_mask_r <= 7'd1;
      ram_present_r   <= 1'b0;
      ram_bank_mask_r <= 2'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ROM_BANK_MASK: rom_bank_mask_r <= cfg_wdata;
        CFG_RAM_PRESENT:   ram_present_r   <= cfg_wdata[0];
        CFG_RAM_BANK_MASK: ram_bank_mask_r <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ram_en_r    <= 1'b0;
      low_bank_r  <= 5'd1;
      upper_r     <= 2'd0;
      mode_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        ram_en_r   <= ram_en_nxt;
        low_bank_r <= low_bank_nxt;
        upper_r    <= upper_nxt;
        mode_r     <= mode_nxt;
      end
      if (in_tready) begin
        out_valid_r <= in_tvalid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      src_r      <= src_nxt;
      rom_addr_r <= rom_addr_nxt;
    end
  end

  // Single-port cartridge RAM; each access is either a read or a write.
  always_ff @(posedge clk) begin
    if (in_acc && ram_we) begin
      cart_ram[ram_idx] <= wbyte;
    end
    if (in_acc && ram_re) begin
      ram_q_r <= cart_ram[ram_idx];
    end
  end

  always_comb begin
    case (src_r)
      SRC_RAM: read_byte = ram_q_r;
      SRC_ROM: read_byte = 8'd0;
      default: read_byte = OPEN_BUS;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = src_r;
  assign out_tdata  = {3'd0, read_byte, rom_addr_r};

  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("accepted access produced no result");

  a_low_bank_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    low_bank_r != 5'd0)
    else $error("low ROM bank register holds zero");

  a_write_open_bus: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == OP_WRITE |=> out_tuser == SRC_NONE)
    else $error("write access returned a data source");

  a_ram_gated: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !(ram_en_r && ram_present_r) |=> out_tuser != SRC_RAM)
    else $error("RAM served while absent or disabled");

endmodule

[tb/cartridge_bank_mapper_checker.sv]
`timescale 1ns / 1ps

module cartridge_bank_mapper_checker
  import cbm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_wdata,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,   // [15:0] bus_address, [23:16] write_byte
  input  logic        in_tuser,   // [0] operation
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,  // [20:0] rom_address, [28:21] read_byte
  input  logic [1:0]  out_tuser,  // [1:0] source
  output int          mismatches,
  output int          outstanding
);

  typedef struct packed {
    src_t        source;
    logic [20:0] rom_address;
    logic [7:0]  read_byte;
  } bus_reply_t;

  logic [6:0] rom_mask;
  logic       ram_fitted;
  logic [1:0] ram_mask;

  logic       ram_on;
  logic [4:0] low_bank;
  logic [1:0] upper_bits;
  logic       mode_sel;
  logic [7:0] cart_ram [RAM_DEPTH];

  bus_reply_t replies_due [$];

  function automatic logic [RAM_AW-1:0] ram_slot(input logic [15:0] addr);
    logic [1:0] bank;
    bank = mode_sel ? (upper_bits & ram_mask) : 2'd0;
    return RAM_AW'({bank, addr[12:0]} % RAM_DEPTH);
  endfunction

  // Applies one bus access to the bank state and returns the reply it gives.
  function automatic bus_reply_t map_access(input op_t op, input logic [15:0] addr,
                                            input logic [7:0] data);
    bus_reply_t reply;
    logic [6:0] bank;
    logic       ram_hit;
    reply   = '{SRC_NONE, 21'd0, OPEN_BUS};
    ram_hit = ram_on && ram_fitted && addr[15:13] == REGION_CART_RAM;
    if (op == OP_WRITE) begin
      case (addr[15:13])
        REGION_RAM_EN:   ram_on = (data[3:0] == RAM_EN_KEY);
        REGION_ROM_BANK: low_bank = (data[4:0] == 5'd0) ? 5'd1 : data[4:0];
        REGION_UPPER:    upper_bits = data[1:0];
        REGION_MODE:     mode_sel = data[0];
        default: begin
          if (ram_hit) cart_ram[ram_slot(addr)] = data;
        end
      endcase
    end else if (!addr[15]) begin
      // The fixed low half only follows the upper bits in the second mode.
      if (!addr[14]) begin
        bank = mode_sel ? ({upper_bits, 5'd0} & rom_mask & ROM_LIMIT_MASK) : 7'd0;
      end else begin
        bank = {upper_bits, low_bank} & rom_mask & ROM_LIMIT_MASK;
      end
      reply.source      = SRC_ROM;
      reply.rom_address = {bank, addr[13:0]};
      reply.read_byte   = 8'd0;
    end else if (ram_hit) begin
      reply.source    = SRC_RAM;
      reply.read_byte = cart_ram[ram_slot(addr)];
    end
    return reply;
  endfunction

  always @(posedge clk) begin
    bus_reply_t want;
    bus_reply_t got;
    if (!rst_n) begin
      rom_mask   = 7'd1;
      ram_fitted = 1'b0;
      ram_mask   = 2'd0;
      ram_on     = 1'b0;
      low_bank   = 5'd1;
      upper_bits = 2'd0;
      mode_sel   = 1'b0;
      mismatches = 0;
      replies_due.delete();
      outstanding <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_ROM_BANK_MASK: rom_mask = cfg_wdata;
          CFG_RAM_PRESENT:   ram_fitted = cfg_wdata[0];
          CFG_RAM_BANK_MASK: ram_mask = cfg_wdata[1:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        got = '{src_t'(out_tuser), out_tdata[20:0], out_tdata[28:21]};
        if (replies_due.size() == 0) begin
          $error("result transaction with none expected: source %0d", got.source);
          mismatches++;
        end else begin
          want = replies_due.pop_front();
          if (got.source !== want.source) begin
            $error("source: expected %0d, got %0d", want.source, got.source);
            mismatches++;
          end
          if (got.rom_address !== want.rom_address) begin
            $error("rom_address: expected 0x%06h, got 0x%06h",
                   want.rom_address, got.rom_address);
            mismatches++;
          end
          if (got.read_byte !== want.read_byte) begin
            $error("read_byte: expected 0x%02h, got 0x%02h", want.read_byte, got.read_byte);
            mismatches++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        replies_due.push_back(map_access(op_t'(in_tuser), in_tdata[15:0], in_tdata[23:16]));
      end
      outstanding <= replies_due.size();
    end
  end

endmodule

[tb/cartridge_bank_mapper_top_tb.sv]
`timescale 1ns / 1ps

module cartridge_bank_mapper_top_tb
  import cbm_pkg::*;
();

  localparam int CYCLE_LIMIT        = 200000;
  localparam int PHASES             = 9;
  localparam int ACCESSES_PER_PHASE = 200;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        cfg_we     = 1'b0;
  logic [1:0]  cfg_index  = '0;
  logic [6:0]  cfg_wdata  = '0;
  logic        in_tvalid  = 1'b0;
  logic [23:0] in_tdata   = '0;
  logic        in_tuser   = 1'b0;
  logic        out_tready = 1'b0;
  logic        in_tready;
  logic        out_tvalid;
  logic [31:0] out_tdata;
  logic [1:0]  out_tuser;

  int mismatches;
  int outstanding;
  int cycle_count = 0;
  int sent_count  = 0;
  int ram_hits    = 0;
  bit steady      = 1'b0;

  // Bank state as the stimulus sees it, kept only so that no read reaches a
  // RAM byte that has never been stored.
  logic       gen_ram_on   = 1'b0;
  logic [1:0] gen_upper    = 2'd0;
  logic       gen_mode     = 1'b0;
  logic       gen_fitted   = 1'b0;
  logic [1:0] gen_ram_mask = 2'd0;
  bit         stored [RAM_DEPTH];

  cartridge_bank_mapper_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  cartridge_bank_mapper_checker mapper_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_tready <= steady || ($urandom_range(99) >= 26);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("cartridge_bank_mapper_top_tb: errors");
      $finish;
    end
  end

  task automatic send_access(input op_t op, input logic [15:0] addr, input logic [7:0] data);
    logic                reach;
    logic [RAM_AW-1:0]   slot;
    reach = gen_ram_on && gen_fitted && addr[15:13] == REGION_CART_RAM;
    slot  = RAM_AW'({(gen_mode ? (gen_upper & gen_ram_mask) : 2'd0), addr[12:0]} % RAM_DEPTH);
    // A byte that was never stored may not be read, so store to it instead.
    if (op == OP_READ && reach && !stored[slot]) op = OP_WRITE;
    while (!steady && $urandom_range(99) < 26) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {data, addr};
    do @(posedge clk); while (!in_tready);
    sent_count++;
    if (op == OP_READ) begin
      if (reach) ram_hits++;
    end else begin
      case (addr[15:13])
        REGION_RAM_EN: gen_ram_on = (data[3:0] == RAM_EN_KEY);
        REGION_UPPER:  gen_upper = data[1:0];
        REGION_MODE:   gen_mode = data[0];
        default: begin
          if (reach) stored[slot] = 1'b1;
        end
      endcase
    end
  endtask

  // Bank masks are only changed once every reply of the previous setting is in.
  task automatic set_banks(input logic [6:0] rom_mask, input logic fitted,
                           input logic [1:0] ram_mask);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ROM_BANK_MASK;
    cfg_wdata <= rom_mask;
    @(posedge clk);
    cfg_index <= CFG_RAM_PRESENT;
    cfg_wdata <= {6'd0, fitted};
    @(posedge clk);
    cfg_index <= CFG_RAM_BANK_MASK;
    cfg_wdata <= {5'd0, ram_mask};
    @(posedge clk);
    cfg_we       <= 1'b0;
    gen_fitted   = fitted;
    gen_ram_mask = ram_mask;
  endtask

  task automatic random_access();
    int          pick;
    logic [15:0] addr;
    logic [12:0] offset;
    logic [7:0]  data;
    pick = $urandom_range(99);
    data = 8'($urandom);
    if (pick < 30) begin
      addr = {1'b0, 15'($urandom)};
      // Keep the RAM switched on most of the time so that RAM traffic lands.
      if (addr[14:13] == 2'b00 && $urandom_range(9) < 7) data[3:0] = RAM_EN_KEY;
      send_access(OP_WRITE, addr, data);
    end else if (pick < 58) begin
      send_access(OP_READ, {1'b0, 15'($urandom)}, data);
    end else if (pick < 85) begin
      // A small pool of RAM offsets, so that reads find stored bytes often.
      case ($urandom_range(3))
        0:       offset[12:4] = 9'h000;
        1:       offset[12:4] = 9'h1FF;
        2:       offset[12:4] = 9'h0AA;
        default: offset[12:4] = 9'h155;
      endcase
      offset[3:0] = 4'($urandom);
      send_access(op_t'($urandom_range(1)), {REGION_CART_RAM, offset}, data);
    end else begin
      send_access(op_t'($urandom_range(1)), 16'($urandom), data);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    set_banks(7'd127, 1'b1, 2'd3);
    send_access(OP_READ,  16'h0000, 8'h00);
    send_access(OP_READ,  16'h7FFF, 8'hFF);
    send_access(OP_WRITE, 16'h2000, 8'h00);   // bank zero selects bank one
    send_access(OP_READ,  16'h4000, 8'h00);
    send_access(OP_WRITE, 16'h3FFF, 8'hE0);   // zero after masking to five bits
    send_access(OP_READ,  16'h4001, 8'h00);
    send_access(OP_WRITE, 16'h2000, 8'h1F);
    send_access(OP_WRITE, 16'h4000, 8'hFF);
    send_access(OP_READ,  16'h7FFF, 8'h00);
    send_access(OP_READ,  16'h3FFF, 8'h00);
    send_access(OP_WRITE, 16'h6000, 8'h01);   // second banking mode
    send_access(OP_READ,  16'h0000, 8'h00);
    send_access(OP_READ,  16'hA000, 8'h00);   // RAM still disabled
    send_access(OP_WRITE, 16'h0000, 8'h0A);
    send_access(OP_WRITE, 16'hBFFF, 8'hA5);
    send_access(OP_READ,  16'hBFFF, 8'h00);
    send_access(OP_WRITE, 16'h1FFF, 8'hFB);   // wrong key switches RAM off
    send_access(OP_READ,  16'hBFFF, 8'h00);
    send_access(OP_WRITE, 16'h1234, 8'h5A);
    send_access(OP_READ,  16'h8000, 8'h00);
    send_access(OP_READ,  16'hC000, 8'h00);
    send_access(OP_READ,  16'hFFFF, 8'h00);
    send_access(OP_WRITE, 16'h9FFF, 8'hFF);
    send_access(OP_WRITE, 16'hFFFF, 8'h00);
    send_access(OP_WRITE, 16'h7FFF, 8'hFE);
    send_access(OP_WRITE, 16'hA000, 8'h00);
    send_access(OP_READ,  16'hA000, 8'h00);

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       set_banks(7'd127, 1'b1, 2'd3);
        1:       set_banks(7'd1, 1'b0, 2'd0);
        2:       set_banks(7'd1, 1'b1, 2'd0);
        3:       set_banks(7'd127, 1'b1, 2'd3);
        default: set_banks(7'((1 << $urandom_range(7, 1)) - 1), $urandom_range(9) < 8,
                           2'($urandom_range(3)));
      endcase
      steady = (phase == 3);
      repeat (ACCESSES_PER_PHASE) random_access();
    end
    steady = 1'b0;

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("Covered %0d bus accesses over %0d bank mask settings, %0d of them RAM reads",
             sent_count, PHASES + 1, ram_hits);
    if (mismatches == 0) begin
      $display("cartridge_bank_mapper_top_tb: clean");
    end else begin
      $display("cartridge_bank_mapper_top_tb: errors");
    end
    $finish;
  end

endmodule
